// File: design/gmvt_pkg.sv
// ----------------------------------------------------------------------------
// gmvt_pkg: shared types and codes of the GF(2) matrix-vector transform
// Command codes, configuration register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gmvt_pkg;

    localparam int ROW_IDX_BITS = 6;
    localparam int MATRIX_DEPTH = 64;
    localparam int ACT_EQ_BITS  = 7;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DATA_BITS = 7;

    // transaction kind carried on tuser
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_XFORM = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_USE_COLUMNS = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ACTIVE_EQ   = 1'd1;

    localparam logic [ACT_EQ_BITS-1:0] ACTIVE_EQ_RESET = 7'd64;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// File: design/gmvt_ram.sv
// ----------------------------------------------------------------------------
// gmvt_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gmvt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: design/gf2_matrix_vector_transform_top.sv
// ----------------------------------------------------------------------------
// gf2_matrix_vector_transform_top: GF(2) matrix times coefficient vector
// Holds a square bit matrix loaded row by row and returns one product word per
// transform, walking the matrix one row per cycle.
// ----------------------------------------------------------------------------
//  channel   | direction | fields (lowest bit first)
//  s_axis    | in        | tuser: command; tdata: row_index, data_word, pad
//  m_axis    | out       | tdata: product, pad
//  i_cfg_*   | in        | index 0 use_columns, index 1 active_equations
//
//  A load returns nothing. A transform steps the matrix RAM one row per
//  cycle (registered read) in the run state, then masks the result into the
//  output register in the done state and returns to idle. The output
//  register lets a new item be taken while a result still waits; a stalled
//  output holds the sequencer in its final state. Reset is synchronous and
//  clears control and configuration; matrix rows are undefined until loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gf2_matrix_vector_transform_top #(
    parameter int VECTOR_BITS = 64
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    // configuration write port
    input  wire logic                                       i_cfg_we,
    input  wire logic [gmvt_pkg::CFG_IDX_BITS-1:0]          i_cfg_index,
    input  wire logic [gmvt_pkg::CFG_DATA_BITS-1:0]         i_cfg_data,
    // input stream
    input  wire logic                                       s_axis_tvalid,
    output logic                                            s_axis_tready,
    // tdata: row_index [5:0], data_word, zero pad
    input  wire logic [((6+VECTOR_BITS+7)/8)*8-1:0]         s_axis_tdata,
    // tuser: command
    input  wire logic                                       s_axis_tuser,
    // output stream
    output logic                                            m_axis_tvalid,
    input  wire logic                                       m_axis_tready,
    // tdata: product, zero pad
    output logic      [((VECTOR_BITS+7)/8)*8-1:0]           m_axis_tdata
);

    import gmvt_pkg::*;

    localparam int W        = VECTOR_BITS;
    localparam int CNT_BITS = $clog2(W + 1);
    localparam int OUT_BITS = ((W + 7) / 8) * 8;
    localparam int RA_BITS  = $clog2(MATRIX_DEPTH);

    t_state r_state, n_state;

    logic                   r_use_cols;
    logic [ACT_EQ_BITS-1:0] r_active;

    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic [W-1:0]        r_vec;
    logic [W-1:0]        r_sel, n_sel;
    logic [W-1:0]        r_acc, n_acc;

    logic                r_out_vld;
    logic [W-1:0]        r_out_data;

    logic                in_acc;
    logic                out_free;
    logic                ram_we;
    logic [RA_BITS-1:0]  ram_raddr;
    logic [W-1:0]        ram_rdata;
    logic [W-1:0]        in_word;
    logic [W-1:0]        eq_mask;
    logic                row_bit;

    assign in_word  = s_axis_tdata[ROW_IDX_BITS +: W];
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_vld || m_axis_tready;

    gmvt_ram #(
        .WIDTH (W),
        .DEPTH (MATRIX_DEPTH)
    ) u_matrix (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (s_axis_tdata[RA_BITS-1:0]),
        .i_wdata (in_word),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_cols <= 1'b0;
            r_active   <= ACTIVE_EQ_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_USE_COLUMNS: r_use_cols <= i_cfg_data[0];
                CFG_ACTIVE_EQ:   r_active   <= i_cfg_data[ACT_EQ_BITS-1:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && s_axis_tuser == CMD_XFORM) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_cnt == CNT_BITS'(W)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_axis_tready = 1'b0;
        ram_we        = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                ram_we        = s_axis_tvalid && s_axis_tuser == CMD_LOAD;
            end
            ST_RUN:  ;
            ST_DONE: ;
            default: ;
        endcase
    end

    assign ram_raddr = RA_BITS'(r_cnt);

    // one matrix row per step: row mode emits one parity bit, column mode
    // folds in the row when the vector bit for that row is set
    assign row_bit = ^(ram_rdata & r_vec);

    always_comb begin
        n_cnt = r_cnt;
        n_sel = r_sel;
        n_acc = r_acc;
        if (r_state == ST_IDLE) begin
            n_cnt = '0;
            n_sel = in_word;
            n_acc = '0;
        end else if (r_state == ST_RUN) begin
            // hold the counter at the last row while the result waits
            if (r_cnt != CNT_BITS'(W)) begin
                n_cnt = r_cnt + CNT_BITS'(1);
            end
            if (r_cnt != '0) begin
                n_sel = r_sel >> 1;
                if (r_use_cols) begin
                    n_acc = r_acc ^ (r_sel[0] ? ram_rdata : '0);
                end else begin
                    n_acc = (r_acc >> 1) | (W'(row_bit) << (W - 1));
                end
            end
        end
    end

    always_comb begin
        for (int j = 0; j < W; j++) begin
            eq_mask[j] = ACT_EQ_BITS'(j) < r_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (r_state == ST_DONE && out_free) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && in_acc) begin
            r_vec <= in_word;
        end
        r_sel <= n_sel;
        r_acc <= n_acc;
        if (r_state == ST_DONE && out_free) begin
            r_out_data <= r_acc & eq_mask;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OUT_BITS'(r_out_data);

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_BITS'(W))
        else $error("row counter beyond vector width");

    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> !ram_we)
        else $error("matrix written during a transform");

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_cnt == CNT_BITS'(W)) |=> r_state == ST_DONE)
        else $error("transform did not finish after the last row");

    a_result_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && out_free) |=> r_out_vld)
        else $error("finished transform produced no result");

    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state) == ST_DONE)
        else $error("result appeared without a finished transform");

endmodule

`default_nettype wire

// File: tb/tb_gf2_matrix_vector_transform_top.sv
// ----------------------------------------------------------------------------
// tb_gf2_matrix_vector_transform_top: self-checking bench for the GF(2) transform
// Clears the matrix, walks a short directed plan that covers the extremes of
// the vector, the row index and the equation count in both row and column
// mode, then streams random loads and transforms under changing register
// settings and three stall patterns. Plan steps with a typed value are checked against it,
// every other product against a bit-level predictor of the matrix multiply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_gf2_matrix_vector_transform_top;

    import gmvt_pkg::*;

    localparam int VECTOR_BITS = 64;
    localparam int IN_BITS     = ((6 + VECTOR_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = ((VECTOR_BITS + 7) / 8) * 8;
    localparam int SETTLE      = VECTOR_BITS + 8;
    localparam int PLAN_LEN    = 27;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_XFORM,
        OP_SET_COLS,
        OP_SET_EQS
    } t_plan_op;

    typedef struct packed {
        t_plan_op     op;
        logic [5:0]   row;
        logic [63:0]  word;
        logic         typed;
        logic [63:0]  want;
    } t_plan_step;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    // tdata: row_index, data_word, zero pad
    logic [IN_BITS-1:0]        s_axis_tdata = '0;
    // tuser: command
    logic                      s_axis_tuser = 1'b0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    // tdata: product, zero pad
    logic [OUT_BITS-1:0]       m_axis_tdata;

    // shadow copy of the block state
    logic [63:0]               matrix_shadow [0:63];
    logic                      use_cols_shadow;
    logic [6:0]                eq_count_shadow;
    logic [63:0]               expected_products [$];

    int unsigned               send_idle_pct = 0;
    int unsigned               recv_idle_pct = 0;
    int unsigned               n_loads = 0;
    int unsigned               n_xforms = 0;
    int unsigned               n_reg_writes = 0;
    int unsigned               n_checked = 0;
    int unsigned               n_mismatches = 0;

    t_plan_step                plan [0:PLAN_LEN-1];

    gf2_matrix_vector_transform_top #(
        .VECTOR_BITS(VECTOR_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Row mode: bit j is the parity of row j AND v. Column mode: XOR of the
    // rows picked by v, i.e. v times the matrix. Counts above 64 saturate.
    function automatic logic [63:0] gf2_product(input logic [63:0] vec);
        logic [63:0] acc;
        int          eqs;
        acc = '0;
        eqs = (eq_count_shadow > 7'd64) ? 64 : int'(eq_count_shadow);
        if (use_cols_shadow) begin
            for (int k = 0; k < 64; k++)
                if (vec[k]) acc ^= matrix_shadow[k];
            if (eqs < 64) acc &= (64'd1 << eqs) - 64'd1;
        end else begin
            for (int k = 0; k < eqs; k++)
                acc[k] = ^(matrix_shadow[k] & vec);
        end
        return acc;
    endfunction

    function automatic logic [63:0] rand_word();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return 64'd1 << $urandom_range(63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin : product_check
        logic [63:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_products.size() == 0) begin
                n_mismatches++;
                if (n_mismatches <= 10)
                    $display("unexpected product %h", m_axis_tdata);
            end else begin
                want = expected_products.pop_front();
                n_checked++;
                if (m_axis_tdata !== want) begin
                    n_mismatches++;
                    if (n_mismatches <= 10)
                        $display("product mismatch: want %h got %h", want, m_axis_tdata);
                end
            end
        end
    end

    // Offer one transaction, with a random gap first, and update the shadow
    // state when it is taken. Valid is left high for a back-to-back follower.
    task automatic send_item(input logic cmd, input logic [5:0] row, input logic [63:0] word,
                             input logic typed, input logic [63:0] want);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {{(IN_BITS - 70){1'b0}}, word, row};
        do @(posedge i_clk); while (!s_axis_tready);
        if (cmd == CMD_LOAD) begin
            matrix_shadow[row] = word;
            n_loads++;
        end else begin
            expected_products.push_back(typed ? want : gf2_product(word));
            n_xforms++;
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_products.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_USE_COLUMNS) use_cols_shadow = val[0];
        else eq_count_shadow = val;
        n_reg_writes++;
    endtask

    initial begin
        logic [6:0] eq_picks [0:7];
        logic [6:0] eqs;
        int         ph;

        eq_picks = '{7'd0, 7'd1, 7'd2, 7'd31, 7'd63, 7'd64, 7'd65, 7'd127};
        plan = '{
            '{OP_XFORM,    6'd0,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h0},
            '{OP_LOAD,     6'd0,  64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
            '{OP_XFORM,    6'd0,  64'h1,                   1'b1, 64'h1},
            '{OP_XFORM,    6'd0,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h0},
            '{OP_LOAD,     6'd63, 64'h8000_0000_0000_0001, 1'b0, 64'h0},
            '{OP_XFORM,    6'd0,  64'h8000_0000_0000_0000, 1'b1, 64'h8000_0000_0000_0001},
            '{OP_SET_EQS,  6'd0,  64'd1,                   1'b0, 64'h0},
            '{OP_XFORM,    6'd0,  64'h8000_0000_0000_0000, 1'b1, 64'h1},
            '{OP_SET_EQS,  6'd0,  64'd0,                   1'b0, 64'h0},
            '{OP_XFORM,    6'd0,  64'h8000_0000_0000_0000, 1'b1, 64'h0},
            '{OP_SET_EQS,  6'd0,  64'd127,                 1'b0, 64'h0},
            '{OP_XFORM,    6'd0,  64'h8000_0000_0000_0000, 1'b1, 64'h8000_0000_0000_0001},
            '{OP_SET_COLS, 6'd0,  64'd1,                   1'b0, 64'h0},
            '{OP_XFORM,    6'd0,  64'h1,                   1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
            '{OP_XFORM,    6'd0,  64'h8000_0000_0000_0000, 1'b1, 64'h8000_0000_0000_0001},
            '{OP_XFORM,    6'd0,  64'h8000_0000_0000_0001, 1'b1, 64'h7FFF_FFFF_FFFF_FFFE},
            '{OP_SET_EQS,  6'd0,  64'd1,                   1'b0, 64'h0},
            '{OP_XFORM,    6'd0,  64'h1,                   1'b1, 64'h1},
            '{OP_SET_EQS,  6'd0,  64'd0,                   1'b0, 64'h0},
            '{OP_XFORM,    6'd0,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h0},
            '{OP_LOAD,     6'd42, 64'h0123_4567_89AB_CDEF, 1'b0, 64'h0},
            '{OP_LOAD,     6'd21, 64'h5555_5555_5555_5555, 1'b0, 64'h0},
            '{OP_SET_EQS,  6'd0,  64'd64,                  1'b0, 64'h0},
            '{OP_XFORM,    6'd0,  64'h0000_0400_0020_0001, 1'b0, 64'h0},
            '{OP_SET_COLS, 6'd0,  64'd0,                   1'b0, 64'h0},
            '{OP_XFORM,    6'd0,  64'hFFFF_0000_FFFF_0000, 1'b0, 64'h0},
            '{OP_XFORM,    6'd0,  64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'h0}
        };

        use_cols_shadow = 1'b0;
        eq_count_shadow = ACTIVE_EQ_RESET;
        for (int r = 0; r < 64; r++) matrix_shadow[r] = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // clear every row so that no transform ever reads an unwritten one
        for (int r = 0; r < 64; r++) send_item(CMD_LOAD, 6'(r), '0, 1'b0, '0);

        for (int i = 0; i < PLAN_LEN; i++) begin
            case (plan[i].op)
                OP_LOAD:     send_item(CMD_LOAD, plan[i].row, plan[i].word, 1'b0, '0);
                OP_XFORM:    send_item(CMD_XFORM, '0, plan[i].word, plan[i].typed,
                                       plan[i].want);
                OP_SET_COLS: write_reg(CFG_USE_COLUMNS, plan[i].word[6:0]);
                default:     write_reg(CFG_ACTIVE_EQ, plan[i].word[6:0]);
            endcase
        end

        // sender idles lightly and the receiver heavily, then the roles swap, then neither idles
        for (ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 62 : 0;
            recv_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 9 : 0;
            for (int seg = 0; seg < 4; seg++) begin
                // upper data bits of the mode register are don't-care
                write_reg(CFG_USE_COLUMNS, {6'($urandom), 1'($urandom)});
                eqs = ($urandom_range(1) != 0) ? eq_picks[$urandom_range(7)]
                                               : 7'($urandom_range(127));
                write_reg(CFG_ACTIVE_EQ, eqs);
                for (int n = 0; n < 58; n++) begin
                    if ($urandom_range(99) < 40)
                        send_item(CMD_LOAD, 6'($urandom_range(63)), rand_word(), 1'b0, '0);
                    else
                        send_item(CMD_XFORM, 6'($urandom), rand_word(), 1'b0, '0);
                end
            end
        end

        drain();
        $display("Covered %0d row loads and %0d transforms over %0d register writes,",
                 n_loads, n_xforms, n_reg_writes);
        $display("%0d products checked; row and column mode, equation counts 0 to 127.",
                 n_checked);
        if (n_mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
design/gmvt_pkg.sv
design/gmvt_ram.sv
design/gf2_matrix_vector_transform_top.sv
tb/tb_gf2_matrix_vector_transform_top.sv
